FILE: hw/rtl/nsf_pkg.sv
// ----------------------------------------------------------------------------
// nsf_pkg
// Shared constants and types for the NMEA sentence framer.
// ----------------------------------------------------------------------------
package nsf_pkg;

   // Sentence buffer size in bytes. Legal range is 8 to 128.
   localparam int BUFFER_BYTES = 128;
   localparam int POS_W        = $clog2(BUFFER_BYTES);

   // Characters the framer reacts to
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_G      = 8'h47;
   localparam logic [7:0] CH_P      = 8'h50;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;

   // Sentence type codes
   typedef enum logic [3:0] {
      TYPE_UNKNOWN = 4'd0,
      TYPE_GGA     = 4'd1,
      TYPE_GLL     = 4'd2,
      TYPE_GSA     = 4'd3,
      TYPE_GSV     = 4'd4,
      TYPE_RMC     = 4'd5,
      TYPE_VTG     = 4'd6,
      TYPE_ZDA     = 4'd7,
      TYPE_DTM     = 4'd8
   } sentence_type_type;

   localparam int NUM_IDS = 8;

   // Message identifiers, first character in the top byte.
   // Entry k maps to type code k+1.
   localparam logic [23:0] TYPE_IDS [NUM_IDS] = '{
      "GGA", "GLL", "GSA", "GSV", "RMC", "VTG", "ZDA", "DTM"
   };

endpackage

FILE: hw/rtl/nsf_type_decode.sv
// ----------------------------------------------------------------------------
// nsf_type_decode
// Matches the three identifier bytes of a sentence against the known ids.
// ----------------------------------------------------------------------------
module nsf_type_decode (
   input  logic [23:0] id_word,
   output logic [3:0]  type_code
);

   always_comb begin
      type_code = nsf_pkg::TYPE_UNKNOWN;
      // ids are all distinct, so at most one entry matches
      for (int k = 0; k < nsf_pkg::NUM_IDS; k++) begin
         if (id_word == nsf_pkg::TYPE_IDS[k]) begin
            type_code = 4'(k + 1);
         end
      end
   end

endmodule

FILE: hw/rtl/nmea_sentence_framer.sv
// ----------------------------------------------------------------------------
// nmea_sentence_framer
// Frames "$GP" sentences from a byte stream and tags each stored byte.
// ----------------------------------------------------------------------------
// One received byte goes in per req beat and exactly one rsp beat comes out
// for it. The framer hunts for '$', 'G', 'P'; from there on every byte is
// reported with its position (byte_valid, byte_value, byte_index) so that a
// downstream buffer can hold the sentence. After CR the next byte must be LF;
// that LF closes the sentence with sentence_done, the length including CR and
// LF, and a type code from the identifier at positions 3 to 5 (0 unknown,
// 1 GGA .. 8 DTM). If the sentence fills the buffer (BUFFER_BYTES in the
// package) the last byte is still reported but sentence_dropped is raised and
// the hunt restarts; a byte other than LF after CR is not stored, raises
// sentence_dropped and restarts the hunt as well. Neither the rejected byte
// nor a wrong 'G'/'P' is rechecked as a new '$'.
// One byte is taken per clock while req_ready is high: the framer state is
// updated and the result is computed in the same cycle a byte is taken, into
// a single output register. req_ready is low only while a result is held in
// the output register and rsp_ready is low.
// ----------------------------------------------------------------------------
module nmea_sentence_framer (
   input  logic       clock,
   input  logic       reset,
   // byte input
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   // per-byte result
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_byte_valid,
   output logic [7:0] rsp_byte_value,
   output logic [6:0] rsp_byte_index,
   output logic       rsp_sentence_done,
   output logic [3:0] rsp_sentence_type,
   output logic [7:0] rsp_sentence_length,
   output logic       rsp_sentence_dropped
);

   localparam int POS_W = nsf_pkg::POS_W;

   typedef enum logic [2:0] {
      MODE_HUNT = 3'd0,
      MODE_G    = 3'd1,
      MODE_P    = 3'd2,
      MODE_DATA = 3'd3,
      MODE_LF   = 3'd4
   } mode_type;

   // Framer state
   mode_type         mode_ff, mode_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       id_ff [3];
   logic [7:0]       id_in [3];

   // Output register
   logic       rsp_valid_ff;
   logic       byte_valid_ff, byte_valid_in;
   logic [7:0] byte_value_ff, byte_value_in;
   logic [6:0] byte_index_ff, byte_index_in;
   logic       done_ff, done_in;
   logic [3:0] type_ff, type_in;
   logic [7:0] length_ff, length_in;
   logic       dropped_ff, dropped_in;

   logic       accept;
   logic [3:0] decoded_type;
   logic       pos_is_last;
   logic       short_id;

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;

   nsf_type_decode u_type_decode (
      .id_word   ({id_ff[0], id_ff[1], id_ff[2]}),
      .type_code (decoded_type)
   );

   assign pos_is_last = (pos_ff == POS_W'(nsf_pkg::BUFFER_BYTES - 1));
   // LF at position 5 or lower means the id was cut short by CR/LF
   assign short_id    = (pos_ff <= POS_W'(5));

   always_comb begin
      mode_in       = mode_ff;
      pos_in        = pos_ff;
      id_in         = id_ff;
      byte_valid_in = 1'b0;
      byte_value_in = 8'd0;
      byte_index_in = 7'd0;
      done_in       = 1'b0;
      type_in       = nsf_pkg::TYPE_UNKNOWN;
      length_in     = 8'd0;
      dropped_in    = 1'b0;

      case (mode_ff)
         MODE_G: begin
            if (req_rx_byte == nsf_pkg::CH_G) begin
               byte_valid_in = 1'b1;
               byte_index_in = 7'd1;
               mode_in       = MODE_P;
            end else begin
               mode_in = MODE_HUNT;
            end
         end
         MODE_P: begin
            if (req_rx_byte == nsf_pkg::CH_P) begin
               byte_valid_in = 1'b1;
               byte_index_in = 7'd2;
               mode_in       = MODE_DATA;
               pos_in        = POS_W'(3);
               id_in[0]      = 8'd0;
               id_in[1]      = 8'd0;
               id_in[2]      = 8'd0;
            end else begin
               mode_in = MODE_HUNT;
            end
         end
         MODE_DATA: begin
            byte_valid_in = 1'b1;
            byte_index_in = 7'(pos_ff);
            if (pos_ff == POS_W'(3)) id_in[0] = req_rx_byte;
            if (pos_ff == POS_W'(4)) id_in[1] = req_rx_byte;
            if (pos_ff == POS_W'(5)) id_in[2] = req_rx_byte;
            if (req_rx_byte == nsf_pkg::CH_CR) begin
               mode_in = MODE_LF;
            end
            // buffer full: overrides a CR on the last slot
            if (pos_is_last) begin
               dropped_in = 1'b1;
               mode_in    = MODE_HUNT;
               pos_in     = '0;
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
         MODE_LF: begin
            if (req_rx_byte == nsf_pkg::CH_LF) begin
               byte_valid_in = 1'b1;
               byte_index_in = 7'(pos_ff);
               done_in       = 1'b1;
               type_in       = short_id ? 4'(nsf_pkg::TYPE_UNKNOWN) : decoded_type;
               length_in     = 8'(pos_ff) + 8'd1;
            end else begin
               dropped_in = 1'b1;
            end
            pos_in  = '0;
            mode_in = MODE_HUNT;
         end
         default: begin
            // hunting for '$'
            pos_in = '0;
            if (req_rx_byte == nsf_pkg::CH_DOLLAR) begin
               byte_valid_in = 1'b1;
               byte_index_in = 7'd0;
               mode_in       = MODE_G;
            end else begin
               mode_in = MODE_HUNT;
            end
         end
      endcase

      if (byte_valid_in) begin
         byte_value_in = req_rx_byte;
      end
   end

   // Framer state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_HUNT;
         pos_ff        <= '0;
         id_ff[0]      <= 8'd0;
         id_ff[1]      <= 8'd0;
         id_ff[2]      <= 8'd0;
         rsp_valid_ff  <= 1'b0;
         byte_valid_ff <= 1'b0;
         byte_value_ff <= 8'd0;
         byte_index_ff <= 7'd0;
         done_ff       <= 1'b0;
         type_ff       <= nsf_pkg::TYPE_UNKNOWN;
         length_ff     <= 8'd0;
         dropped_ff    <= 1'b0;
      end else begin
         if (accept) begin
            mode_ff       <= mode_in;
            pos_ff        <= pos_in;
            id_ff         <= id_in;
            rsp_valid_ff  <= 1'b1;
            byte_valid_ff <= byte_valid_in;
            byte_value_ff <= byte_value_in;
            byte_index_ff <= byte_index_in;
            done_ff       <= done_in;
            type_ff       <= type_in;
            length_ff     <= length_in;
            dropped_ff    <= dropped_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_byte_valid       = byte_valid_ff;
   assign rsp_byte_value       = byte_value_ff;
   assign rsp_byte_index       = byte_index_ff;
   assign rsp_sentence_done    = done_ff;
   assign rsp_sentence_type    = type_ff;
   assign rsp_sentence_length  = length_ff;
   assign rsp_sentence_dropped = dropped_ff;

endmodule

FILE: hw/rtl/nsf_checker.sv
// ----------------------------------------------------------------------------
// nsf_checker
// Port-level checks for the NMEA sentence framer, bound to the top level.
// ----------------------------------------------------------------------------
module nsf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_byte_valid,
   input logic [7:0] rsp_byte_value,
   input logic [6:0] rsp_byte_index,
   input logic       rsp_sentence_done,
   input logic [3:0] rsp_sentence_type,
   input logic [7:0] rsp_sentence_length,
   input logic       rsp_sentence_dropped
);

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte_valid)
         && $stable(rsp_byte_value) && $stable(rsp_byte_index)
         && $stable(rsp_sentence_done) && $stable(rsp_sentence_type)
         && $stable(rsp_sentence_length) && $stable(rsp_sentence_dropped))
      else $error("rsp beat changed while stalled");

   // a completed sentence ends with a stored LF
   a_done_lf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sentence_done |->
         rsp_byte_valid && rsp_byte_value == nsf_pkg::CH_LF
         && !rsp_sentence_dropped)
      else $error("sentence done without stored LF");

   // length counts the LF itself
   a_done_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sentence_done |->
         rsp_sentence_length[6:0] == rsp_byte_index + 7'd1)
      else $error("sentence length does not match LF position");

   // a stored byte that drops the sentence sits on the last buffer slot
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sentence_dropped && rsp_byte_valid |->
         rsp_byte_index == 7'(nsf_pkg::BUFFER_BYTES - 1))
      else $error("overflow drop away from buffer end");

   // an accepted byte shows up as a result next cycle
   a_beat_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted byte produced no result");

endmodule

bind nmea_sentence_framer nsf_checker u_nsf_checker (.*);

FILE: bench/nmea_sentence_framer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nmea_sentence_framer_tb
// Self-checking bench for the "$GP" sentence framer.
// ----------------------------------------------------------------------------
// Bytes go in on the req channel one beat at a time. Each accepted byte is run
// through a local copy of the framer's mode, store position and identifier
// bytes, and the predicted rsp beat is queued. A checker pops one prediction
// per rsp beat and compares every field. Directed sentences cover broken start
// sequences, short sentences, a missing LF and buffer overflow; the rest is
// random sentences with random content, mixed with noise, run under several
// idle/stall settings on both channels.
// ----------------------------------------------------------------------------
module nmea_sentence_framer_tb;

   localparam int CLOCK_PERIOD = 10;
   localparam int RESET_CYCLES = 6;
   localparam int RANDOM_BYTES = 120;      // directed tests add about 420 more
   localparam int DRAIN_CYCLES = 10;       // rsp trails req through the output register
   localparam int CYCLE_LIMIT  = 200000;

   // Framer mode as the bench tracks it
   typedef enum logic [2:0] {
      HUNT_DOLLAR,
      EXPECT_G,
      EXPECT_P,
      IN_DATA,
      EXPECT_LF
   } framer_mode_type;

   // One predicted rsp beat
   typedef struct packed {
      logic                       byte_valid;
      logic [7:0]                 byte_value;
      logic [6:0]                 byte_index;
      logic                       sentence_done;
      nsf_pkg::sentence_type_type sentence_type;
      logic [7:0]                 sentence_length;
      logic                       sentence_dropped;
   } framer_result_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic [7:0] req_rx_byte = '0;
   logic       rsp_ready   = 1'b0;

   logic       req_ready;
   logic       rsp_valid;
   logic       rsp_byte_valid;
   logic [7:0] rsp_byte_value;
   logic [6:0] rsp_byte_index;
   logic       rsp_sentence_done;
   logic [3:0] rsp_sentence_type;
   logic [7:0] rsp_sentence_length;
   logic       rsp_sentence_dropped;

   // Bench copy of the framer state
   framer_mode_type framer_mode;
   int unsigned     store_pos;
   logic [7:0]      id_bytes [3];

   framer_result_type pending_results [$];
   int unsigned       bytes_sent;
   int unsigned       mismatch_count = 0;
   int unsigned       cycle_count    = 0;

   // Idle odds in percent, changed per phase
   int unsigned    send_idle_pct;
   int unsigned    recv_stall_pct;

   nmea_sentence_framer dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_rx_byte          (req_rx_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_byte_valid       (rsp_byte_valid),
      .rsp_byte_value       (rsp_byte_value),
      .rsp_byte_index       (rsp_byte_index),
      .rsp_sentence_done    (rsp_sentence_done),
      .rsp_sentence_type    (rsp_sentence_type),
      .rsp_sentence_length  (rsp_sentence_length),
      .rsp_sentence_dropped (rsp_sentence_dropped)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Match the three identifier bytes against the message table
   function automatic nsf_pkg::sentence_type_type lookup_sentence_type();
      for (int k = 0; k < nsf_pkg::NUM_IDS; k++) begin
         if ({id_bytes[0], id_bytes[1], id_bytes[2]} == nsf_pkg::TYPE_IDS[k])
            return nsf_pkg::sentence_type_type'(k + 1);
      end
      return nsf_pkg::TYPE_UNKNOWN;
   endfunction

   // Positions 3..5 hold the identifier, CR/LF included if they land there
   function automatic void keep_id_byte(input logic [7:0] b);
      if (store_pos inside {[3:5]})
         id_bytes[store_pos - 3] = b;
   endfunction

   function automatic framer_result_type predict_framer_result(input logic [7:0] b);
      framer_result_type r;
      r = '0;
      case (framer_mode)
         HUNT_DOLLAR: begin
            if (b == nsf_pkg::CH_DOLLAR) begin
               r.byte_valid = 1'b1;
               r.byte_index = 7'd0;
               framer_mode  = EXPECT_G;
            end
         end
         EXPECT_G: begin
            // a wrong byte here is not itself retried as '$'
            if (b == nsf_pkg::CH_G) begin
               r.byte_valid = 1'b1;
               r.byte_index = 7'd1;
               framer_mode  = EXPECT_P;
            end else begin
               framer_mode = HUNT_DOLLAR;
            end
         end
         EXPECT_P: begin
            if (b == nsf_pkg::CH_P) begin
               r.byte_valid = 1'b1;
               r.byte_index = 7'd2;
               framer_mode  = IN_DATA;
               store_pos    = 3;
               id_bytes     = '{8'd0, 8'd0, 8'd0};
            end else begin
               framer_mode = HUNT_DOLLAR;
            end
         end
         IN_DATA: begin
            r.byte_valid = 1'b1;
            r.byte_index = store_pos[6:0];
            keep_id_byte(b);
            store_pos++;
            if (b == nsf_pkg::CH_CR)
               framer_mode = EXPECT_LF;
            // last buffer slot: byte is kept but the sentence is dropped
            if (store_pos >= nsf_pkg::BUFFER_BYTES) begin
               r.sentence_dropped = 1'b1;
               framer_mode        = HUNT_DOLLAR;
               store_pos          = 0;
            end
         end
         default: begin
            if (b == nsf_pkg::CH_LF) begin
               r.byte_valid      = 1'b1;
               r.byte_index      = store_pos[6:0];
               keep_id_byte(b);
               r.sentence_done   = 1'b1;
               r.sentence_type   = lookup_sentence_type();
               r.sentence_length = 8'(store_pos + 1);
            end else begin
               r.sentence_dropped = 1'b1;
            end
            store_pos   = 0;
            framer_mode = HUNT_DOLLAR;
         end
      endcase
      if (r.byte_valid)
         r.byte_value = b;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Result channel: random stalls and checking
   // ------------------------------------------------------------------------

   function automatic void check_field(input string name, input int unsigned expected_v,
                                       input int unsigned actual_v);
      if (expected_v != actual_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, expected_v, actual_v);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_ready <= reset ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
   end

   // Values read here are the ones from before the edge, so a beat counts
   // exactly when the design sees valid and ready together.
   always @(posedge clock) begin : result_check
      framer_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("rsp beat with no byte outstanding");
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("byte_valid", want.byte_valid, rsp_byte_valid);
            check_field("byte_value", want.byte_value, rsp_byte_value);
            check_field("byte_index", want.byte_index, rsp_byte_index);
            check_field("sentence_done", want.sentence_done, rsp_sentence_done);
            check_field("sentence_type", want.sentence_type, rsp_sentence_type);
            check_field("sentence_length", want.sentence_length, rsp_sentence_length);
            check_field("sentence_dropped", want.sentence_dropped, rsp_sentence_dropped);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Byte channel
   // ------------------------------------------------------------------------

   // Random idle gap, then hold the byte until its beat; valid stays high
   // afterwards so back-to-back bytes need no extra cycle.
   task automatic send_rx_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do
         @(posedge clock);
      while (!req_ready);
      pending_results.push_back(predict_framer_result(b));
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_rx_byte(s[i]);
   endtask

   // Sentence body byte: never CR, so the sentence only ends where intended
   function automatic logic [7:0] random_body_byte();
      logic [7:0] b;
      b = $urandom_range(1) ? 8'($urandom_range(8'h20, 8'h7E)) : 8'($urandom_range(0, 255));
      if (b == nsf_pkg::CH_CR)
         b = 8'h2A;
      return b;
   endfunction

   function automatic logic [7:0] random_non_lf();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (b == nsf_pkg::CH_LF)
         b = nsf_pkg::CH_DOLLAR;
      return b;
   endfunction

   task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Broken start sequences; the byte that breaks one is not a new '$'
   task automatic test_start_chars();
      send_text("$X");
      send_text("$G$");
      send_text("GP");
      send_text("$GX");
   endtask

   // CR inside the identifier field gives an unknown type
   task automatic test_short_sentences();
      send_text("$GP");
      send_rx_byte(nsf_pkg::CH_CR);
      send_rx_byte(nsf_pkg::CH_LF);
      send_text("$GPGG");
      send_rx_byte(nsf_pkg::CH_CR);
      send_rx_byte(nsf_pkg::CH_LF);
   endtask

   // Non-LF after CR drops the sentence; that '$' is swallowed
   task automatic test_missing_lf();
      send_text("$GPGGA");
      send_rx_byte(nsf_pkg::CH_CR);
      send_rx_byte(nsf_pkg::CH_DOLLAR);
      send_rx_byte(nsf_pkg::CH_LF);
   endtask

   task automatic send_long_sentence(input int data_bytes, input bit end_cr, input bit end_lf);
      send_text("$GP");
      repeat (data_bytes)
         send_rx_byte(random_body_byte());
      if (end_cr)
         send_rx_byte(nsf_pkg::CH_CR);
      if (end_lf)
         send_rx_byte(nsf_pkg::CH_LF);
   endtask

   // Fill to the last slot with data, with a CR, and a full-length sentence
   task automatic test_overflow();
      send_long_sentence(nsf_pkg::BUFFER_BYTES - 3, 1'b0, 1'b0);
      send_rx_byte(nsf_pkg::CH_LF);
      send_long_sentence(nsf_pkg::BUFFER_BYTES - 4, 1'b1, 1'b0);
      send_rx_byte(nsf_pkg::CH_LF);
      send_long_sentence(nsf_pkg::BUFFER_BYTES - 5, 1'b1, 1'b1);
   endtask

   // Mostly well-formed sentences with random ids and bodies; some noise,
   // broken starts, truncated ids and missing LFs mixed in.
   task automatic send_random_burst();
      int unsigned pick;
      int unsigned id_sel;
      int unsigned id_len;
      pick = $urandom_range(99);
      if (pick < 8) begin
         repeat ($urandom_range(1, 4))
            send_rx_byte(8'($urandom_range(0, 255)));
      end else if (pick < 14) begin
         send_rx_byte(nsf_pkg::CH_DOLLAR);
         if ($urandom_range(1))
            send_rx_byte(nsf_pkg::CH_G);
         send_rx_byte(8'($urandom_range(0, 255)));
      end else begin
         send_text("$GP");
         id_sel = $urandom_range(0, nsf_pkg::NUM_IDS);   // NUM_IDS picks random id bytes
         id_len = ($urandom_range(9) == 0) ? $urandom_range(0, 2) : 3;
         for (int i = 0; i < id_len; i++) begin
            if (id_sel < nsf_pkg::NUM_IDS)
               send_rx_byte(nsf_pkg::TYPE_IDS[id_sel][23 - 8 * i -: 8]);
            else
               send_rx_byte(random_body_byte());
         end
         if (id_len == 3) begin
            repeat ($urandom_range(0, 12))
               send_rx_byte(random_body_byte());
         end
         send_rx_byte(nsf_pkg::CH_CR);
         send_rx_byte(($urandom_range(9) != 0) ? nsf_pkg::CH_LF : random_non_lf());
      end
   endtask

   task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct);
      int unsigned stop_at;
      set_idling(send_pct, recv_pct);
      stop_at = bytes_sent + RANDOM_BYTES / 4;
      while (bytes_sent < stop_at)
         send_random_burst();
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      framer_mode    = HUNT_DOLLAR;
      store_pos      = 0;
      id_bytes       = '{8'd0, 8'd0, 8'd0};
      bytes_sent     = 0;
      set_idling(0, 0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_start_chars();
      test_short_sentences();
      test_missing_lf();

      set_idling(29, 29);
      test_overflow();

      // no idling, sender gaps, receiver stalls, then both
      test_random_traffic(0, 0);
      test_random_traffic(70, 0);
      test_random_traffic(0, 70);
      test_random_traffic(29, 29);

      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/nsf_pkg.sv
hw/rtl/nsf_type_decode.sv
hw/rtl/nmea_sentence_framer.sv
hw/rtl/nsf_checker.sv
bench/nmea_sentence_framer_tb.sv
